// ===== design/page_overlay_write_allocate_memory_core_assert.svh =====
// Assertion macros for the page overlay core.
// Included by the files that check their own logic; needs no package.
`ifndef PAGE_OVERLAY_WRITE_ALLOCATE_MEMORY_CORE_ASSERT_SVH
`define PAGE_OVERLAY_WRITE_ALLOCATE_MEMORY_CORE_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define POW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pow: same-cycle check failed");
// Next-cycle implication.
`define POW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pow: next-cycle check failed");
`else
`define POW_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define POW_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/pow_pkg.sv =====
// Shared constants, codes and types of the page overlay core.
// No dependencies; compiled first.
package pow_pkg;

	localparam int SLAB_COUNT = 16;
	localparam int PAGE_BYTES = 16;
	localparam int ADDR_BITS  = 12;

	localparam int OFF_W      = $clog2(PAGE_BYTES);
	localparam int PAGE_W     = ADDR_BITS - OFF_W;
	localparam int SLAB_IW    = (SLAB_COUNT > 1) ? $clog2(SLAB_COUNT) : 1;
	localparam int SLAB_AW    = SLAB_IW + OFF_W;
	localparam int SLAB_DEPTH = SLAB_COUNT * PAGE_BYTES;
	localparam int SPACE_BYTES = 1 << ADDR_BITS;
	localparam int LIMIT_W    = ADDR_BITS + 1;
	localparam int CNT_W      = OFF_W + 1;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(SPACE_BYTES);

	localparam logic [1:0] ACT_READ  = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_LOAD  = 2'd2;
	localparam logic [1:0] ACT_FREE  = 2'd3;

	localparam logic [1:0] STS_OK   = 2'd0;
	localparam logic [1:0] STS_FAIL = 2'd1;
	localparam logic [1:0] STS_FULL = 2'd2;

	typedef struct packed {
		logic [1:0]           action;
		logic [ADDR_BITS-1:0] address;
		logic [7:0]           write_data;
		logic                 last_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [1:0] status;
		logic       access_end;
	} out_item_t;

	// Sequencer to slab directory.
	typedef struct packed {
		logic                start;
		logic                clear;
		logic                claim;
		logic [PAGE_W-1:0]   page;
		logic [SLAB_IW-1:0]  slot;
	} dir_req_t;

	// Slab directory to sequencer.
	typedef struct packed {
		logic               done;
		logic               hit;
		logic [SLAB_IW-1:0] hit_slot;
		logic               free;
		logic [SLAB_IW-1:0] free_slot;
	} dir_rsp_t;

endpackage

// ===== design/pow_if.sv =====
// Valid/ready channels that carry input and result items.
// Depends on pow_pkg for the payload types.
interface pow_in_if;
	import pow_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t item;
	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface pow_out_if;
	import pow_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t item;
	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

// ===== design/page_overlay_write_allocate_memory_core.sv =====
// Writable page overlay over a read-only backing byte store: top level.
// Depends on pow_pkg, pow_if, pow_dir and the assertion macro header.
`include "page_overlay_write_allocate_memory_core_assert.svh"

// One byte item is handled at a time; in_ch.ready is high only while the
// sequencer is idle, and a finished result sits in an output register so the
// next item can be taken while it waits. A load or free item goes from idle
// straight to the response state. A read or write first walks the slab
// directory with one shared tag comparator, one slab per cycle, stopping at
// the holder or after the last slab. A read then passes through the registered
// memory read (states RD and RDT) before the response state; a write to a held
// page, a failed read or a write to a full pool goes straight to it. A write
// that claims a slab copies the page from the backing store through its single
// read port, one byte per cycle; bytes at or above backing_limit copy in as 0
// and the written byte lands in the same pass. A stalled receiver holds the
// sequencer in its response state. The backing store (4096 bytes) and slab
// store (SLAB_COUNT*PAGE_BYTES bytes) are plain synchronous RAMs with no reset
// and no clearing pass; only the slab valid bits reset. backing_limit resets
// to 4096; the user must write it through cfg_we/cfg_wdata only while the
// block is idle, and the block itself does not enforce this.
module page_overlay_write_allocate_memory_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [pow_pkg::LIMIT_W-1:0]  cfg_wdata,
	pow_in_if.sink                       in_ch,
	pow_out_if.source                    out_ch
);
	import pow_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_RD   = 3'd2;
	localparam logic [2:0] ST_RDT  = 3'd3;
	localparam logic [2:0] ST_COPY = 3'd4;
	localparam logic [2:0] ST_RESP = 3'd5;

	logic [2:0]           state_q;
	logic [LIMIT_W-1:0]   limit_q;

	// held item
	logic [1:0]           act_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic [7:0]           data_q;
	logic                 last_q;

	// result being formed
	logic [7:0]           res_rd_q;
	logic [1:0]           res_st_q;
	logic                 src_slab_q;
	logic [SLAB_IW-1:0]   slot_q;
	logic [CNT_W-1:0]     cnt_q;

	// copy write stage
	logic                 wr_s1;
	logic [OFF_W-1:0]     off_s1;
	logic                 fail_s1;

	logic                 out_valid_q;
	out_item_t            out_item_q;

	// memories
	logic [7:0]           backing_mem [SPACE_BYTES];
	logic [7:0]           slab_mem [SLAB_DEPTH];
	logic [7:0]           bk_rdata_q;
	logic [7:0]           sl_rdata_q;

	logic                 accept;
	logic [PAGE_W-1:0]    page_q;
	logic [OFF_W-1:0]     off_q;
	logic                 addr_fail;
	logic [ADDR_BITS-1:0] copy_addr;
	logic                 copy_fail;
	logic                 bk_we;
	logic [ADDR_BITS-1:0] bk_raddr;
	logic [SLAB_AW-1:0]   sl_raddr;
	logic                 sl_we;
	logic [SLAB_AW-1:0]   sl_waddr;
	logic [7:0]           sl_wdata;
	logic                 hit_write;
	logic                 out_free;

	dir_req_t             dreq;
	dir_rsp_t             drsp;

	assign accept    = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE);
	assign out_ch.valid = out_valid_q;
	assign out_ch.item  = out_item_q;
	assign out_free  = !out_valid_q || out_ch.ready;

	assign page_q    = addr_q[ADDR_BITS-1:OFF_W];
	assign off_q     = addr_q[OFF_W-1:0];
	assign addr_fail = ({1'b0, addr_q} >= limit_q);
	assign copy_addr = {page_q, cnt_q[OFF_W-1:0]};
	assign copy_fail = ({1'b0, copy_addr} >= limit_q);

	// Directory control: start a walk on every read or write item.
	assign dreq.start = accept &&
		((in_ch.item.action == ACT_READ) || (in_ch.item.action == ACT_WRITE));
	assign dreq.clear = accept && (in_ch.item.action == ACT_FREE);
	assign dreq.claim = (state_q == ST_SCAN) && drsp.done && (act_q == ACT_WRITE) &&
		!drsp.hit && drsp.free;
	assign dreq.slot  = drsp.free_slot;
	assign dreq.page  = (state_q == ST_IDLE) ? in_ch.item.address[ADDR_BITS-1:OFF_W] :
		page_q;

	pow_dir u_dir (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	// Backing store: loads write at the accept edge; one read port serves
	// both byte reads and slab fills.
	assign bk_we    = accept && (in_ch.item.action == ACT_LOAD);
	assign bk_raddr = (state_q == ST_COPY) ? copy_addr : addr_q;

	always_ff @(posedge clk) begin
		if (bk_we) begin
			backing_mem[in_ch.item.address] <= in_ch.item.write_data;
		end
		bk_rdata_q <= backing_mem[bk_raddr];
	end

	// Slab store: a write to a held page goes straight in; otherwise the fill
	// stage writes one byte a cycle, substituting the item's byte at its offset.
	assign hit_write = (state_q == ST_SCAN) && drsp.done && (act_q == ACT_WRITE) &&
		drsp.hit;
	assign sl_raddr  = {slot_q, off_q};

	always_comb begin
		sl_we    = 1'b0;
		sl_waddr = {slot_q, off_s1};
		sl_wdata = fail_s1 ? 8'd0 : bk_rdata_q;
		if (hit_write) begin
			sl_we    = 1'b1;
			sl_waddr = {drsp.hit_slot, off_q};
			sl_wdata = data_q;
		end else if (wr_s1) begin
			sl_we = 1'b1;
			if (off_s1 == off_q) begin
				sl_wdata = data_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sl_we) begin
			slab_mem[sl_waddr] <= sl_wdata;
		end
		sl_rdata_q <= slab_mem[sl_raddr];
	end

	// Fill pipeline: the read issued at count k returns in the next cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_s1 <= 1'b0;
		end else begin
			wr_s1 <= (state_q == ST_COPY) && !cnt_q[OFF_W];
		end
	end

	always_ff @(posedge clk) begin
		off_s1  <= cnt_q[OFF_W-1:0];
		fail_s1 <= copy_fail;
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if ((in_ch.item.action == ACT_READ) ||
							(in_ch.item.action == ACT_WRITE)) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_RESP;
						end
					end
				end
				ST_SCAN: begin
					if (drsp.done) begin
						if (act_q == ACT_READ) begin
							state_q <= (drsp.hit || !addr_fail) ? ST_RD : ST_RESP;
						end else if (!drsp.hit && drsp.free) begin
							cnt_q   <= '0;
							state_q <= ST_COPY;
						end else begin
							state_q <= ST_RESP;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_RDT;
				end
				ST_RDT: begin
					state_q <= ST_RESP;
				end
				ST_COPY: begin
					if (cnt_q[OFF_W]) begin
						// last byte is written this cycle
						state_q <= ST_RESP;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_RESP: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Item and result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q    <= in_ch.item.action;
			addr_q   <= in_ch.item.address;
			data_q   <= in_ch.item.write_data;
			last_q   <= in_ch.item.last_byte;
			res_rd_q <= 8'd0;
			res_st_q <= STS_OK;
		end
		if ((state_q == ST_SCAN) && drsp.done) begin
			src_slab_q <= drsp.hit;
			slot_q     <= drsp.hit ? drsp.hit_slot : drsp.free_slot;
			if (act_q == ACT_READ) begin
				if (!drsp.hit && addr_fail) begin
					res_st_q <= STS_FAIL;
				end
			end else if (!drsp.hit && !drsp.free) begin
				res_st_q <= STS_FULL;
			end
		end
		if (state_q == ST_RDT) begin
			res_rd_q <= src_slab_q ? sl_rdata_q : bk_rdata_q;
		end
		if ((state_q == ST_RESP) && out_free) begin
			out_item_q.read_data  <= res_rd_q;
			out_item_q.status     <= res_st_q;
			out_item_q.access_end <= last_q;
		end
	end

	// Checks on the sequencer and directory handoff.
	`POW_ASSERT_NOW(a_done_in_scan, clk, arst_n, drsp.done, state_q == ST_SCAN)
	`POW_ASSERT_NOW(a_fill_in_copy, clk, arst_n, wr_s1, state_q == ST_COPY)
	`POW_ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, state_q != ST_IDLE)
	`POW_ASSERT_NOW(a_claim_no_hit, clk, arst_n, dreq.claim, !hit_write)

endmodule

// ===== design/pow_dir.sv =====
// Slab directory: valid bits, page tags and one shared tag comparator that
// walks the slabs one per cycle. Depends on pow_pkg.
module pow_dir (
	input  logic              clk,
	input  logic              arst_n,
	input  pow_pkg::dir_req_t req,
	output pow_pkg::dir_rsp_t rsp
);
	import pow_pkg::*;

	logic [SLAB_COUNT-1:0] valid_q;
	logic [PAGE_W-1:0]     page_q [SLAB_COUNT];
	logic [PAGE_W-1:0]     key_q;
	logic                  scan_q;
	logic [SLAB_IW-1:0]    idx_q;
	logic                  done_q;
	logic                  hit_q;
	logic                  free_q;
	logic [SLAB_IW-1:0]    hit_slot_q;
	logic [SLAB_IW-1:0]    free_slot_q;

	logic match;
	logic empty;
	logic last;

	assign empty = !valid_q[idx_q];
	assign match = valid_q[idx_q] && (page_q[idx_q] == key_q);
	assign last  = (idx_q == SLAB_IW'(SLAB_COUNT - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			scan_q  <= 1'b0;
			idx_q   <= '0;
			done_q  <= 1'b0;
			hit_q   <= 1'b0;
			free_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.clear) begin
				valid_q <= '0;
			end else if (req.claim) begin
				valid_q[req.slot] <= 1'b1;
			end
			if (req.start) begin
				scan_q <= 1'b1;
				idx_q  <= '0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end else if (scan_q) begin
				if (empty && !free_q) begin
					free_q <= 1'b1;
				end
				if (match || last) begin
					// stop at the first holder or after the last slab
					scan_q <= 1'b0;
					done_q <= 1'b1;
					hit_q  <= match;
				end else begin
					idx_q <= idx_q + SLAB_IW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			key_q <= req.page;
		end
		if (req.claim) begin
			page_q[req.slot] <= req.page;
		end
		if (scan_q && match) begin
			hit_slot_q <= idx_q;
		end
		if (scan_q && empty && !free_q) begin
			free_slot_q <= idx_q;
		end
	end

	assign rsp.done      = done_q;
	assign rsp.hit       = hit_q;
	assign rsp.hit_slot  = hit_slot_q;
	assign rsp.free      = free_q;
	assign rsp.free_slot = free_slot_q;

endmodule

// ===== verif/page_overlay_write_allocate_memory_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the page overlay core: directed table, then random accesses.
// Depends on pow_pkg, pow_if and page_overlay_write_allocate_memory_core.
module page_overlay_write_allocate_memory_core_tb;
	import pow_pkg::*;

	// Cycles in which no item moves on either channel before the run is declared
	// hung. The receiver stalls at most half the time, so this is many times the
	// slowest legal gap.
	localparam int QUIET_LIMIT   = 3000;
	// Tail after the last result: covers the longest item latency with margin.
	localparam int SETTLE_CYCLES = 40;
	localparam int HOT_PAGES     = 24;
	localparam int PHASE_ITEMS   = 270;

	// One row of the directed table: either a limit write or an item, and for
	// items whose result is obvious, the typed-in result.
	typedef struct packed {
		bit                 is_cfg;
		logic [LIMIT_W-1:0] limit;
		in_item_t           item;
		bit                 typed;
		out_item_t          reply;
	} drill_row_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [LIMIT_W-1:0] cfg_wdata;

	pow_in_if  in_ch ();
	pow_out_if out_ch ();

	page_overlay_write_allocate_memory_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// Shadow copy of the overlay: limit register, slab directory, slab bytes and
	// the backing store image. Entries of the backing image stay X until loaded.
	logic [LIMIT_W-1:0] store_limit = LIMIT_RESET;
	bit                 slab_held [SLAB_COUNT];
	logic [PAGE_W-1:0]  slab_tag  [SLAB_COUNT];
	logic [7:0]         slab_mem  [SLAB_DEPTH];
	logic [7:0]         rom_image [SPACE_BYTES];
	// Backing bytes the stimulus has loaded; nothing may read a byte not set here.
	bit                 rom_loaded [SPACE_BYTES];

	out_item_t  replies_due [$];
	drill_row_t drill [$];

	int send_gap_pct   = 27;
	int recv_stall_pct = 50;
	int sent_count     = 0;
	int fault_count    = 0;
	int quiet_cycles   = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: drop ready at random, at the rate of the current phase.
	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Work out the result of one byte access and advance the shadow state.
	function automatic out_item_t apply_access(in_item_t x);
		out_item_t         r;
		logic [PAGE_W-1:0] pg;
		logic [OFF_W-1:0]  off;
		logic [ADDR_BITS-1:0] a;
		int                slot;
		int                i;
		r = '0;
		r.status = STS_OK;
		r.access_end = x.last_byte;
		pg = x.address[ADDR_BITS-1:OFF_W];
		off = x.address[OFF_W-1:0];
		slot = -1;
		for (i = 0; i < SLAB_COUNT; i++)
			if (slot < 0 && slab_held[i] && slab_tag[i] == pg)
				slot = i;
		case (x.action)
			ACT_READ: begin
				if (slot >= 0)
					r.read_data = slab_mem[slot * PAGE_BYTES + off];
				else if ({1'b0, x.address} < store_limit)
					r.read_data = rom_image[x.address];
				else
					r.status = STS_FAIL;
			end
			ACT_WRITE: begin
				if (slot < 0) begin
					// Claim the lowest free slab and copy the page in; bytes past
					// the limit come in as zero without an error.
					for (i = 0; i < SLAB_COUNT; i++)
						if (slot < 0 && !slab_held[i])
							slot = i;
					if (slot >= 0) begin
						slab_held[slot] = 1'b1;
						slab_tag[slot] = pg;
						for (i = 0; i < PAGE_BYTES; i++) begin
							a = {pg, OFF_W'(i)};
							slab_mem[slot * PAGE_BYTES + i] =
								({1'b0, a} < store_limit) ? rom_image[a] : 8'h00;
						end
					end
				end
				if (slot >= 0)
					slab_mem[slot * PAGE_BYTES + off] = x.write_data;
				else
					r.status = STS_FULL;
			end
			ACT_LOAD: rom_image[x.address] = x.write_data;
			default: begin
				for (i = 0; i < SLAB_COUNT; i++)
					slab_held[i] = 1'b0;
			end
		endcase
		return r;
	endfunction

	function automatic drill_row_t step_row(logic [1:0] act, logic [ADDR_BITS-1:0] adr,
			logic [7:0] dat, logic lst);
		drill_row_t r;
		r = '0;
		r.item = {act, adr, dat, lst};
		return r;
	endfunction

	function automatic drill_row_t known_row(logic [1:0] act, logic [ADDR_BITS-1:0] adr,
			logic [7:0] dat, logic lst, logic [7:0] rd, logic [1:0] st);
		drill_row_t r;
		r = step_row(act, adr, dat, lst);
		r.typed = 1'b1;
		r.reply = {rd, st, lst};
		return r;
	endfunction

	function automatic drill_row_t limit_row(logic [LIMIT_W-1:0] v);
		drill_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.limit = v;
		return r;
	endfunction

	// Offer one item after a random gap, hold it until taken, then record what
	// the block must answer. Valid stays high so a back-to-back item follows.
	task automatic send_access(in_item_t x, bit typed = 1'b0, out_item_t reply = '0);
		out_item_t want;
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.item <= x;
		@(posedge clk);
		while (in_ch.ready !== 1'b1)
			@(posedge clk);
		want = apply_access(x);
		if (x.action == ACT_LOAD)
			rom_loaded[x.address] = 1'b1;
		replies_due.push_back(typed ? reply : want);
		sent_count++;
	endtask

	// Load every backing byte the access may read and that is still unwritten:
	// the one byte of a read, or the whole page for a write that may claim a slab.
	task automatic back_fill(in_item_t x);
		in_item_t             ld;
		logic [ADDR_BITS-1:0] a;
		int                   n;
		int                   i;
		n = (x.action == ACT_READ) ? 1 : (x.action == ACT_WRITE) ? PAGE_BYTES : 0;
		for (i = 0; i < n; i++) begin
			a = (x.action == ACT_READ) ? x.address
				: {x.address[ADDR_BITS-1:OFF_W], OFF_W'(i)};
			if ({1'b0, a} < store_limit && !rom_loaded[a]) begin
				ld.action = ACT_LOAD;
				ld.address = a;
				ld.write_data = 8'($urandom);
				ld.last_byte = 1'b1;
				send_access(ld);
			end
		end
	endtask

	// Drop valid, wait for every outstanding result, then let the block go idle.
	task automatic settle();
		in_ch.valid <= 1'b0;
		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_limit(logic [LIMIT_W-1:0] v);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		store_limit = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Result checker: compare every taken result with the oldest expectation.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (replies_due.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("%0t: result item with none outstanding: rd=%02h st=%0d end=%0d",
						$realtime, out_ch.item.read_data, out_ch.item.status,
						out_ch.item.access_end);
			end else begin
				want = replies_due.pop_front();
				if (out_ch.item.read_data !== want.read_data ||
						out_ch.item.status !== want.status ||
						out_ch.item.access_end !== want.access_end) begin
					fault_count++;
					if (fault_count <= 10)
						$display("%0t: mismatch: expected rd=%02h st=%0d end=%0d, got rd=%02h st=%0d end=%0d",
							$realtime, want.read_data, want.status, want.access_end,
							out_ch.item.read_data, out_ch.item.status,
							out_ch.item.access_end);
				end
			end
		end
	end

	// Hang detector: count cycles in which neither channel moves an item.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no item moved for %0d cycles", $realtime, QUIET_LIMIT);
				$display("** page_overlay_write_allocate_memory_core: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		logic [PAGE_W-1:0]    hot_pages [HOT_PAGES];
		logic [ADDR_BITS-1:0] base;
		in_item_t             x;
		int                   phase;
		int                   phase_end;
		int                   pick;
		int                   len;
		int                   k;
		int                   i;

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		in_ch.valid <= 1'b0;
		in_ch.item <= '0;

		// Directed table. Both ends of the address space first, then a zero
		// limit so every backing read fails: a claimed slab fills with zero and
		// still reports ok, the pool runs full, and a free drops every slab.
		// Back at the full limit, a load after a claim must not touch the slab.
		drill.push_back(known_row(ACT_LOAD, 12'h000, 8'h00, 1'b1, 8'h00, STS_OK));
		drill.push_back(known_row(ACT_LOAD, 12'hFFF, 8'hFF, 1'b0, 8'h00, STS_OK));
		drill.push_back(known_row(ACT_READ, 12'hFFF, 8'h00, 1'b1, 8'hFF, STS_OK));
		drill.push_back(known_row(ACT_READ, 12'h000, 8'hFF, 1'b0, 8'h00, STS_OK));
		drill.push_back(limit_row('0));
		drill.push_back(known_row(ACT_READ, 12'hFFF, 8'h00, 1'b1, 8'h00, STS_FAIL));
		drill.push_back(known_row(ACT_WRITE, 12'h005, 8'h5A, 1'b0, 8'h00, STS_OK));
		drill.push_back(known_row(ACT_READ, 12'h006, 8'h00, 1'b1, 8'h00, STS_OK));
		// Claim the remaining slabs as one multi-byte run over scattered pages.
		for (i = 1; i < SLAB_COUNT; i++)
			drill.push_back(step_row(ACT_WRITE, {PAGE_W'(i * 17), OFF_W'(i)},
				8'($urandom), 1'(i == SLAB_COUNT - 1)));
		drill.push_back(known_row(ACT_WRITE, 12'h800, 8'hC3, 1'b1, 8'h00, STS_FULL));
		drill.push_back(known_row(ACT_READ, 12'h005, 8'h00, 1'b0, 8'h5A, STS_OK));
		drill.push_back(known_row(ACT_FREE, 12'h000, 8'h00, 1'b1, 8'h00, STS_OK));
		drill.push_back(known_row(ACT_READ, 12'h005, 8'h00, 1'b1, 8'h00, STS_FAIL));
		drill.push_back(limit_row(LIMIT_RESET));
		drill.push_back(step_row(ACT_WRITE, 12'hFF3, 8'h81, 1'b0));
		drill.push_back(known_row(ACT_LOAD, 12'hFFF, 8'h11, 1'b1, 8'h00, STS_OK));
		drill.push_back(step_row(ACT_READ, 12'hFFF, 8'h00, 1'b0));
		drill.push_back(step_row(ACT_READ, 12'hFF3, 8'h00, 1'b1));
		drill.push_back(known_row(ACT_FREE, 12'hFFF, 8'hFF, 1'b1, 8'h00, STS_OK));
		drill.push_back(step_row(ACT_READ, 12'hFFF, 8'h00, 1'b1));

		// Working set: more pages than slabs so the pool fills between frees,
		// with both ends of the page range always in it.
		hot_pages[0] = '0;
		hot_pages[1] = '1;
		for (i = 2; i < HOT_PAGES; i++)
			hot_pages[i] = PAGE_W'($urandom);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (drill[r]) begin
			if (drill[r].is_cfg)
				set_limit(drill[r].limit);
			else begin
				back_fill(drill[r].item);
				send_access(drill[r].item, drill[r].typed, drill[r].reply);
			end
		end

		// Random part, one phase per idling pattern, each under its own limit.
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_gap_pct = 27;
					recv_stall_pct = 50;
					set_limit(LIMIT_RESET);
				end
				1: begin
					send_gap_pct = 50;
					recv_stall_pct = 27;
					set_limit(LIMIT_W'($urandom_range(1, SPACE_BYTES - 1)));
				end
				default: begin
					send_gap_pct = 0;
					recv_stall_pct = 0;
					set_limit(LIMIT_W'($urandom_range(0, SPACE_BYTES)));
				end
			endcase
			phase_end = sent_count + PHASE_ITEMS;
			while (sent_count < phase_end) begin
				pick = $urandom_range(0, 99);
				base = ($urandom_range(0, 9) == 0) ? ADDR_BITS'($urandom)
					: {hot_pages[$urandom_range(0, HOT_PAGES - 1)], OFF_W'($urandom)};
				x.address = base;
				x.write_data = 8'($urandom);
				x.last_byte = 1'($urandom);
				if (pick < 3) begin
					x.action = ACT_FREE;
					send_access(x);
				end else if (pick < 15) begin
					x.action = ACT_LOAD;
					send_access(x);
				end else begin
					// A multi-byte access: consecutive bytes, last_byte on the final
					// one; now and then the marking is scrambled.
					x.action = (pick < 55) ? ACT_READ : ACT_WRITE;
					len = $urandom_range(1, 4);
					for (k = 0; k < len; k++) begin
						x.address = base + ADDR_BITS'(k);
						x.write_data = 8'($urandom);
						x.last_byte = (k == len - 1);
						if ($urandom_range(0, 9) == 0)
							x.last_byte = 1'($urandom);
						back_fill(x);
						send_access(x);
					end
				end
			end
		end

		settle();
		if (fault_count == 0 && replies_due.size() == 0)
			$display("** page_overlay_write_allocate_memory_core: PASSED **");
		else
			$display("** page_overlay_write_allocate_memory_core: FAILED **");
		$finish;
	end

endmodule
